@@ design/mgsc_pkg.sv @@
// ----------------------------------------------------------------------------
// mgsc_pkg: shared types and constants for the marker gated sample capture
// Holds the sample width, the hold-back depth, register indexes, the
// threshold reset values and the structs passed between the modules.
// ----------------------------------------------------------------------------
package mgsc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HOLD_DEPTH = 3;
    localparam int HOLD_CNT_W = 2;
    localparam int REG_IDX_W  = 2;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 2'd1;

    // threshold reset values
    localparam logic signed [SAMPLE_W-1:0] HIGH_THR_RST = 16'sd31000;
    localparam logic signed [SAMPLE_W-1:0] LOW_THR_RST  = -16'sd31000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] high;
        logic signed [SAMPLE_W-1:0] low;
    } mgsc_thr_t;

    // one result word from the front end
    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] smp;
    } mgsc_word_t;

    // front end status
    typedef struct packed {
        logic                  capturing;
        logic [HOLD_CNT_W-1:0] hold_cnt;
    } mgsc_stat_t;

endpackage

@@ design/mgsc_front.sv @@
// ----------------------------------------------------------------------------
// mgsc_front: marker detection and capture hold-back
// Keeps the last three samples, detects the low-high-low-high marker,
// toggles the capture flag and holds captured samples back by three words.
// ----------------------------------------------------------------------------
module mgsc_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   take,
    input  logic                                   kind,
    input  logic signed [mgsc_pkg::SAMPLE_W-1:0]   sample,
    input  mgsc_pkg::mgsc_thr_t                    thr,
    output mgsc_pkg::mgsc_word_t                   word,
    output mgsc_pkg::mgsc_stat_t                   stat
);
    import mgsc_pkg::*;

    logic signed [SAMPLE_W-1:0]   hist_reg [HOLD_DEPTH];
    logic signed [SAMPLE_W-1:0]   hist_next [HOLD_DEPTH];
    logic signed [SAMPLE_W-1:0]   held_reg [HOLD_DEPTH];
    logic signed [SAMPLE_W-1:0]   held_next [HOLD_DEPTH];
    logic [HOLD_CNT_W-1:0]        cnt_reg;
    logic [HOLD_CNT_W-1:0]        cnt_next;
    logic                         cap_reg;
    logic                         cap_next;
    logic                         marker;

    // detect the marker over history and the incoming sample
    assign marker = (hist_reg[2] < thr.low) && (hist_reg[1] > thr.high) &&
                    (hist_reg[0] < thr.low) && (sample > thr.high);

    // classify the item and compute next state
    always_comb
    begin
        hist_next = hist_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        cap_next  = cap_reg;
        word.vld  = 1'b0;
        word.smp  = held_reg[0];
        if (take)
        begin
            if (kind == KIND_CLEAR)
            begin
                for (int i = 0; i < HOLD_DEPTH; i++)
                begin
                    hist_next[i] = '0;
                end
                cnt_next = '0;
                cap_next = 1'b0;
            end
            else
            begin
                if (cap_reg)
                begin
                    if (marker)
                    begin
                        // drop everything held, the closing marker included
                        cnt_next = '0;
                    end
                    else if (cnt_reg == HOLD_CNT_W'(HOLD_DEPTH))
                    begin
                        // release the oldest and shift the rest
                        word.vld = 1'b1;
                        for (int i = 0; i < HOLD_DEPTH - 1; i++)
                        begin
                            held_next[i] = held_reg[i+1];
                        end
                        held_next[HOLD_DEPTH-1] = sample;
                    end
                    else
                    begin
                        // fill the next free slot
                        for (int i = 0; i < HOLD_DEPTH; i++)
                        begin
                            if (cnt_reg == HOLD_CNT_W'(i))
                            begin
                                held_next[i] = sample;
                            end
                        end
                        cnt_next = HOLD_CNT_W'(cnt_reg + 1'b1);
                    end
                end
                if (marker)
                begin
                    cap_next = ~cap_reg;
                end
                // advance history
                for (int i = HOLD_DEPTH - 1; i > 0; i--)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                hist_next[0] = sample;
            end
        end
    end

    // control state and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            cnt_reg <= '0;
            cap_reg <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
            cnt_reg  <= cnt_next;
            cap_reg  <= cap_next;
        end
    end

    // held samples carry no reset
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    assign stat.capturing = cap_reg;
    assign stat.hold_cnt  = cnt_reg;

endmodule

@@ design/mgsc_queue.sv @@
// ----------------------------------------------------------------------------
// mgsc_queue: result word queue
// Small first-in first-out store between the front end and the result
// ports, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mgsc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mgsc_pkg::mgsc_word_t                  wr,
    input  logic                                  pop,
    output logic                                  full,
    output logic                                  empty,
    output logic signed [mgsc_pkg::SAMPLE_W-1:0]  rd_data
);
    import mgsc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       do_wr;
    logic                       do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr.vld && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                          PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                          PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // store the word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr.smp;
        end
    end

endmodule

@@ design/marker_gated_sample_capture.sv @@
// A released word is registered into the result queue when the item that
// releases it is accepted.
// Throughput: one item per cycle while the result queue is not full; items
// are classified combinationally and QUEUE_DEPTH queued words absorb stalls.
// Reset: asynchronous, active low; clears history, capture flag, hold count
// and queue, and loads the threshold reset values. No clearing pass.
// ----------------------------------------------------------------------------
// marker_gated_sample_capture: top level
// Captures audio samples between low-high-low-high markers, holding each
// back by three words so a closing marker never reaches the output.
// ----------------------------------------------------------------------------
module marker_gated_sample_capture
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   kind,
    input  logic signed [mgsc_pkg::SAMPLE_W-1:0]   sample,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [mgsc_pkg::SAMPLE_W-1:0]   captured_sample,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mgsc_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [mgsc_pkg::SAMPLE_W-1:0]          cfg_data
);
    import mgsc_pkg::*;

    mgsc_thr_t  thr_reg;
    mgsc_thr_t  thr_next;
    mgsc_word_t word;
    mgsc_stat_t stat;
    logic       take;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    // decode register writes; unknown indexes are dropped
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HIGH_THR: thr_next.high = cfg_data;
                REG_LOW_THR:  thr_next.low  = cfg_data;
                default:      thr_next      = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.high <= HIGH_THR_RST;
            thr_reg.low  <= LOW_THR_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    mgsc_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .kind   (kind),
        .sample (sample),
        .thr    (thr_reg),
        .word   (word),
        .stat   (stat)
    );

    mgsc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (word),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .rd_data (captured_sample)
    );

    // a clear leaves nothing held and capture off
    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (take && kind == KIND_CLEAR) |=> (!stat.capturing && stat.hold_cnt == '0))
        else $error("clear did not reset capture state");

    // a word is released only from a full hold-back while capturing
    a_release_src: assert property (@(posedge clk) disable iff (!rst_n)
        word.vld |-> (take && stat.capturing &&
                      stat.hold_cnt == HOLD_CNT_W'(HOLD_DEPTH)))
        else $error("word released outside full hold-back");

    // a released word into an empty queue is visible next cycle
    a_release_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (word.vld && empty) |=> !empty)
        else $error("released word lost");

    // hold count never exceeds the hold-back depth
    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hold_cnt <= HOLD_CNT_W'(HOLD_DEPTH))
        else $error("hold count overflow");

endmodule

@@ tb/sv/marker_gated_sample_capture_checker.sv @@
// ----------------------------------------------------------------------------
// marker_gated_sample_capture_checker: scoreboard for the capture block
// Watches the item, result and register channels. It keeps its own copy of
// the thresholds, sample history, capture flag and hold-back buffer. It
// queues every word the block must release and compares each popped word
// with the oldest one queued.
// ----------------------------------------------------------------------------
module marker_gated_sample_capture_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic                                   kind,
    input  logic signed [mgsc_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   pop,
    input  logic                                   empty,
    input  logic signed [mgsc_pkg::SAMPLE_W-1:0]   captured_sample,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [mgsc_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [mgsc_pkg::SAMPLE_W-1:0]          cfg_data,
    output int                                     mismatches,
    output int                                     outstanding
);
    import mgsc_pkg::*;

    // shadow thresholds and capture state
    logic signed [SAMPLE_W-1:0] high_thr;
    logic signed [SAMPLE_W-1:0] low_thr;
    logic signed [SAMPLE_W-1:0] recent [HOLD_DEPTH];
    logic signed [SAMPLE_W-1:0] held [HOLD_DEPTH];
    logic                       capturing;
    int                         held_cnt;

    // words the block still owes, oldest first
    logic signed [SAMPLE_W-1:0] release_q [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         err_cnt;

    // drop history, flag and held words
    task automatic clear_capture();
        for (int i = 0; i < HOLD_DEPTH; i++)
            recent[i] = '0;
        capturing = 1'b0;
        held_cnt  = 0;
    endtask

    // classify one sample and queue the word it releases, if any
    task automatic advance_capture(input logic signed [SAMPLE_W-1:0] s);
        logic at_marker;
        at_marker = recent[2] < low_thr && recent[1] > high_thr &&
                    recent[0] < low_thr && s > high_thr;
        if (capturing) begin
            if (at_marker) begin
                // closing marker: discard everything held
                held_cnt = 0;
            end else if (held_cnt == HOLD_DEPTH) begin
                release_q.push_back(held[0]);
                held[0] = held[1];
                held[1] = held[2];
                held[2] = s;
            end else begin
                held[held_cnt] = s;
                held_cnt++;
            end
        end
        if (at_marker)
            capturing = !capturing;
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = s;
    endtask

    task automatic report(input string what, input logic signed [SAMPLE_W-1:0] exp_w,
                          input logic signed [SAMPLE_W-1:0] got_w);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%t: %s: expected %0d, got %0d", $realtime, what, exp_w, got_w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr = HIGH_THR_RST;
            low_thr  = LOW_THR_RST;
            clear_capture();
            release_q.delete();
            err_cnt = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // accepted item, scored against the thresholds held before this edge
            if (push && !full)
            begin
                if (kind == KIND_CLEAR)
                    clear_capture();
                else
                    advance_capture(sample);
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HIGH_THR: high_thr = cfg_data;
                    REG_LOW_THR:  low_thr  = cfg_data;
                    default: ;
                endcase
            end

            // accepted result word
            if (pop && !empty)
            begin
                if (release_q.size() == 0)
                    report("unexpected word", '0, captured_sample);
                else
                begin
                    want = release_q.pop_front();
                    if (captured_sample !== want)
                        report("captured_sample mismatch", want, captured_sample);
                end
            end

            outstanding <= release_q.size();
            mismatches  <= err_cnt;
        end
    end

endmodule

@@ tb/sv/marker_gated_sample_capture_tb.sv @@
// ----------------------------------------------------------------------------
// marker_gated_sample_capture_tb: stimulus and verdict for the capture block
// Drives a directed run of marker, chunk and clear cases, then phases of
// random chunks framed by markers, noise, clears and broken markers under several
// threshold settings and idling patterns. The checker scores every word.
// ----------------------------------------------------------------------------
module marker_gated_sample_capture_tb;
    import mgsc_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // indexes past the register list; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 48;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic                       kind = KIND_SAMPLE;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SAMPLE_W-1:0] captured_sample;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [REG_IDX_W-1:0]       cfg_index = REG_HIGH_THR;
    logic [SAMPLE_W-1:0]        cfg_data = '0;
    int                         mismatches;
    int                         outstanding;

    // idling percentages and the thresholds the stimulus aims at
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    logic signed [SAMPLE_W-1:0] high_thr = HIGH_THR_RST;
    logic signed [SAMPLE_W-1:0] low_thr = LOW_THR_RST;
    int                         items_sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    marker_gated_sample_capture DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .sample(sample),
        .empty(empty),
        .pop(pop),
        .captured_sample(captured_sample),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    marker_gated_sample_capture_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .sample(sample),
        .pop(pop),
        .empty(empty),
        .captured_sample(captured_sample),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    // receiver: pop unless stalling this cycle
    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hang guard
    initial
    begin
        #(20 * 200000);
        $display("marker_gated_sample_capture_tb: FAIL");
        $finish;
    end

    // present one word, idling first when the sender mode asks
    task automatic send_item(input logic k, input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        kind   <= k;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        send_item(KIND_SAMPLE, s);
    endtask

    // value strictly below the low threshold, any value when none exists
    function automatic logic signed [SAMPLE_W-1:0] pick_low();
        if (low_thr == -32768)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(0, int'(low_thr) + 32767) - 32768);
    endfunction

    // value strictly above the high threshold, any value when none exists
    function automatic logic signed [SAMPLE_W-1:0] pick_high();
        if (high_thr == 32767)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'(int'(high_thr) + 1 + $urandom_range(0, 32766 - int'(high_thr)));
    endfunction

    task automatic send_marker();
        send_sample(pick_low());
        send_sample(pick_high());
        send_sample(pick_low());
        send_sample(pick_high());
    endtask

    // hold off until every owed word is out, then let the pipe settle
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HIGH_THR: high_thr = val;
            REG_LOW_THR:  low_thr  = val;
            default: ;
        endcase
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct <= 67; recv_stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct <= 0;  recv_stall_pct <= 67; end
            default:       begin send_idle_pct <= 6;  recv_stall_pct <= 6;  end
        endcase
        @(posedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] hi_set [NUM_PHASES];
        logic signed [SAMPLE_W-1:0] lo_set [NUM_PHASES];
        int                         goal;
        int                         pick;
        int                         run;

        // threshold settings per phase, extremes among them
        hi_set[0] = HIGH_THR_RST;              lo_set[0] = LOW_THR_RST;
        hi_set[1] = 16'sd32767;                lo_set[1] = -16'sd32768;
        hi_set[2] = -16'sd32768;               lo_set[2] = 16'sd32767;
        hi_set[3] = SAMPLE_W'($urandom_range(0, 32000));
        lo_set[3] = SAMPLE_W'(-$urandom_range(0, 32000));
        hi_set[4] = '0;                        lo_set[4] = '0;
        hi_set[5] = SAMPLE_W'($urandom);       lo_set[5] = SAMPLE_W'($urandom);
        hi_set[6] = 16'sd100;                  lo_set[6] = -16'sd100;
        hi_set[7] = SAMPLE_W'($urandom_range(20000, 32766));
        lo_set[7] = SAMPLE_W'(-$urandom_range(20000, 32767));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear with a nonzero sample, extremes as marker values
        send_item(KIND_CLEAR, 16'sh1234);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        // closing marker right after opening, with one word held
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        // reopen off the tail of the last marker, fill the hold-back, release one
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'sh2aaa);
        // clear while three words are held
        send_item(KIND_CLEAR, -16'sd1);
        send_marker();
        send_sample(16'sd7);
        send_sample(-16'sd7);
        send_sample(16'sd0);
        // closing marker while the hold-back is full
        send_marker();
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(REG_HIGH_THR, hi_set[ph]);
            write_reg(REG_LOW_THR, lo_set[ph]);
            if (ph == 1)
            begin
                write_reg(REG_SPARE_A, SAMPLE_W'($urandom));
                write_reg(REG_SPARE_B, SAMPLE_W'($urandom));
            end
            set_idling(idle_mode_t'(ph % 4));

            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    send_item(KIND_CLEAR, SAMPLE_W'($urandom));
                else if (pick < 72)
                begin
                    // framed chunk with random content
                    send_marker();
                    run = $urandom_range(0, 8);
                    repeat (run) send_sample(SAMPLE_W'($urandom));
                    send_marker();
                end
                else if (pick < 86)
                begin
                    run = $urandom_range(1, 4);
                    repeat (run) send_sample(SAMPLE_W'($urandom));
                end
                else
                begin
                    // broken marker
                    send_sample(pick_low());
                    send_sample(pick_high());
                    send_sample(pick_low());
                    send_sample(SAMPLE_W'($urandom));
                end
            end
            wait_drained();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("marker_gated_sample_capture_tb: PASS");
        else
            $display("marker_gated_sample_capture_tb: FAIL");
        $finish;
    end

endmodule
